// ===== rtl/core/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants for the text console writer: character codes and the
// bit layout of the result word.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [7:0]  SPACE_CODE   = 8'h20;
    localparam logic [7:0]  ATTR_RESET   = 8'h07;

    // result tdata layout, lowest bit first
    localparam int CUR_IDX_LSB   = 0;
    localparam int CUR_IDX_W     = 11;
    localparam int CUR_ROW_LSB   = 11;
    localparam int CUR_ROW_W     = 5;
    localparam int CUR_COL_LSB   = 16;
    localparam int CUR_COL_W     = 7;
    localparam int CELL_IDX_LSB  = 23;
    localparam int CELL_IDX_W    = 11;
    localparam int CELL_VAL_LSB  = 34;
    localparam int CELL_VAL_W    = 16;
    localparam int M_TDATA_W     = 56;

    // result tuser layout
    localparam int USR_WRITTEN   = 0;
    localparam int USR_SCROLLED  = 1;
    localparam int M_TUSER_W     = 2;

endpackage

// ===== rtl/core/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Character stream to text-mode cell store, with cursor tracking and scroll.
// ----------------------------------------------------------------------------
// Each input word carries one character byte. A newline (0x0A) moves the
// cursor to column 0 of the next row; any other byte is written at the cursor
// as {attribute, character} and the column advances, wrapping to the next row
// after the last column. Moving past the last row scrolls the screen up one
// row and blanks the bottom row with spaces in the current attribute. One
// result word is returned per input word with the new cursor, the written
// cell (if any) and a scroll flag. An ordinary character or a newline that
// does not scroll is taken while the result slot is free, and the next word
// may follow at once. For an item that scrolls, the single-port-read cell RAM
// copies rows 1..ROWS-1 up one cell per cycle, then the bottom row is written
// one cell per cycle. The result of a scrolling item is presented right away;
// the next input waits for the copy and the blanking. After reset a clearing
// pass writes every cell to 0x0720, during which no input is taken;
// attribute writes are accepted at any time.
// ----------------------------------------------------------------------------
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // input stream: tdata[7:0] = char_code
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,

    // result stream:
    // tdata[10:0] cursor_index, [15:11] cursor_row, [22:16] cursor_col,
    //      [33:23] cell_index, [49:34] cell_value, [55:50] zero
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // tuser[0] cell_written, [1] scrolled
    output logic [M_TUSER_W-1:0] m_axis_tuser,

    // attribute register write: cfg_data = text_attribute
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int COPY_COUNT = CELL_COUNT - COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,   // post-reset fill with blanks
        ST_IDLE  = 4'b0010,   // take characters
        ST_COPY  = 4'b0100,   // move rows 1..ROWS-1 up by one
        ST_BLANK = 4'b1000    // fill bottom row with spaces
    } state_t;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      cnt_reg, cnt_next;        // sweep address
    logic                   pend_reg, pend_next;      // copy write pending
    logic [ADDR_W-1:0]      pend_addr_reg, pend_addr_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [7:0]             attr_reg, attr_next;
    logic [7:0]             scroll_attr_reg, scroll_attr_next;

    logic                   m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;
    logic [M_TUSER_W-1:0]   m_user_reg, m_user_next;

    // ------------------------------------------------------------------
    // cell RAM: one write port, one registered read port
    // ------------------------------------------------------------------
    logic [15:0]            cell_mem [CELL_COUNT];
    logic [15:0]            mem_rdata_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [15:0]            mem_wdata;
    logic [ADDR_W-1:0]      mem_raddr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= cell_mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // cursor arithmetic for the word being taken
    // ------------------------------------------------------------------
    logic                   in_fire;
    logic                   out_free;
    logic                   is_newline;
    logic                   last_col;
    logic                   last_row;
    logic                   adv_row;
    logic                   do_scroll;
    logic [ROW_W-1:0]       new_row;
    logic [COL_W-1:0]       new_col;
    logic [ADDR_W-1:0]      wr_idx;
    logic [ADDR_W-1:0]      new_pos;
    logic [31:0]            new_pos_w;
    logic [31:0]            new_row_w;
    logic [31:0]            new_col_w;
    logic [31:0]            wr_idx_w;
    logic [15:0]            char_cell;

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign is_newline = (s_axis_tdata == NEWLINE_CODE);
    assign last_col   = (col_reg == COL_W'(COLUMNS - 1));
    assign last_row   = (row_reg == ROW_W'(ROWS - 1));
    assign adv_row    = is_newline || last_col;
    assign do_scroll  = adv_row && last_row;
    assign new_col    = adv_row ? '0 : col_reg + 1'b1;
    assign new_row    = (adv_row && !last_row) ? row_reg + 1'b1 : row_reg;

    // row * COLUMNS + col; constant multiply, narrow
    assign wr_idx  = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign new_pos = ADDR_W'(new_row) * ADDR_W'(COLUMNS) + ADDR_W'(new_col);

    // fields are masked to their port widths for large geometries
    assign new_pos_w = 32'(new_pos);
    assign new_row_w = 32'(new_row);
    assign new_col_w = 32'(new_col);
    assign wr_idx_w  = 32'(wr_idx);
    assign char_cell = {attr_reg, s_axis_tdata};

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        pend_next        = pend_reg;
        pend_addr_next   = pend_addr_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        attr_next        = attr_reg;
        scroll_attr_next = scroll_attr_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        m_user_next      = m_user_reg;

        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = {ATTR_RESET, SPACE_CODE};
        mem_raddr = cnt_reg + ADDR_W'(COLUMNS);

        if (cfg_valid && cfg_ready) begin
            attr_next = cfg_data;
        end

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = {ATTR_RESET, SPACE_CODE};
                if (cnt_reg == ADDR_W'(CELL_COUNT - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_IDLE: begin
                if (in_fire) begin
                    if (!is_newline) begin
                        mem_we    = 1'b1;
                        mem_waddr = wr_idx;
                        mem_wdata = char_cell;
                    end
                    row_next = new_row;
                    col_next = new_col;

                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next[CUR_IDX_LSB +: CUR_IDX_W] = new_pos_w[CUR_IDX_W-1:0];
                    m_data_next[CUR_ROW_LSB +: CUR_ROW_W] = new_row_w[CUR_ROW_W-1:0];
                    m_data_next[CUR_COL_LSB +: CUR_COL_W] = new_col_w[CUR_COL_W-1:0];
                    if (!is_newline) begin
                        m_data_next[CELL_IDX_LSB +: CELL_IDX_W] = wr_idx_w[CELL_IDX_W-1:0];
                        m_data_next[CELL_VAL_LSB +: CELL_VAL_W] = char_cell;
                    end
                    m_user_next               = '0;
                    m_user_next[USR_WRITTEN]  = !is_newline;
                    m_user_next[USR_SCROLLED] = do_scroll;

                    if (do_scroll) begin
                        // blank row uses the attribute in force now
                        scroll_attr_next = attr_reg;
                        cnt_next         = '0;
                        pend_next        = 1'b0;
                        state_next       = ST_COPY;
                    end
                end
            end

            ST_COPY: begin
                // read cell cnt+COLUMNS now, write it to cnt in the next cycle
                mem_raddr      = cnt_reg + ADDR_W'(COLUMNS);
                mem_we         = pend_reg;
                mem_waddr      = pend_addr_reg;
                mem_wdata      = mem_rdata_reg;
                pend_next      = 1'b1;
                pend_addr_next = cnt_reg;
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == ADDR_W'(COPY_COUNT - 1)) begin
                    state_next = ST_BLANK;
                end
            end

            ST_BLANK: begin
                mem_we = 1'b1;
                if (pend_reg) begin
                    // drain the last copy first
                    mem_waddr = pend_addr_reg;
                    mem_wdata = mem_rdata_reg;
                    pend_next = 1'b0;
                end else begin
                    mem_waddr = cnt_reg;
                    mem_wdata = {scroll_attr_reg, SPACE_CODE};
                    if (cnt_reg == ADDR_W'(CELL_COUNT - 1)) begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end

            default: begin
                state_next = ST_CLEAR;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            row_reg     <= '0;
            col_reg     <= '0;
            attr_reg    <= ATTR_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            attr_reg    <= attr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        pend_addr_reg   <= pend_addr_next;
        scroll_attr_reg <= scroll_attr_next;
        m_data_reg      <= m_data_next;
        m_user_reg      <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

// ===== rtl/core/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker
    import tcw_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [M_TUSER_W-1:0] m_axis_tuser
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // no cell write -> cell fields zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[USR_WRITTEN] |->
            m_axis_tdata[CELL_IDX_LSB +: CELL_IDX_W] == '0 &&
            m_axis_tdata[CELL_VAL_LSB +: CELL_VAL_W] == '0)
        else $error("cell fields set without a write");

    // a scroll always leaves the cursor at column 0
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[USR_SCROLLED] |->
            m_axis_tdata[CUR_COL_LSB +: CUR_COL_W] == '0)
        else $error("scroll with nonzero column");

    // clearing pass blocks input right after reset
    assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_axis_tready && !m_axis_tvalid)
        else $error("input taken during clearing pass");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
